>>> src/wheel_pulse_rpm_meter_defines.svh
// Assertion macros used by the tachometer top level.
`ifndef WHEEL_PULSE_RPM_METER_DEFINES_SVH
`define WHEEL_PULSE_RPM_METER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WPRM_ASSERT_IMPLIES(label, clk, rstn, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WPRM_ASSERT_NEXT(label, clk, rstn, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (expr)) \
        else $error(msg);

`endif

>>> src/wprm_pkg.sv
// Shared types and constants of the wheel pulse tachometer.
package wprm_pkg;

    localparam int WHEEL_COUNT   = 2;
    localparam int WHEEL_IDX_W   = (WHEEL_COUNT > 1) ? $clog2(WHEEL_COUNT) : 1;
    localparam int TIME_WIDTH    = 32;
    localparam int FRACTION_BITS = 8;
    localparam int PPR_WIDTH     = 8;
    localparam int SPEED_WIDTH   = 34;
    localparam int DIV_WIDTH     = TIME_WIDTH + PPR_WIDTH;
    localparam int CNT_WIDTH     = $clog2(SPEED_WIDTH + 1);

    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 32;

    localparam int IN_DATA_W     = ((TIME_WIDTH + 7) / 8) * 8;
    localparam int IN_USER_W     = 2;
    localparam int OUT_DATA_W    = ((WHEEL_COUNT * SPEED_WIDTH + 7) / 8) * 8;
    localparam int OUT_USER_W    = WHEEL_COUNT;

    // Microseconds per minute, scaled by the fraction bits.
    localparam logic [SPEED_WIDTH-1:0] NUMERATOR =
        SPEED_WIDTH'(64'd60000000 << FRACTION_BITS);

    localparam logic [PPR_WIDTH-1:0]  PPR_RESET     = PPR_WIDTH'(1);
    localparam logic [TIME_WIDTH-1:0] TIMEOUT_RESET = TIME_WIDTH'(500000);

    localparam logic [CFG_INDEX_W-1:0] REG_PPR     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT = 2'd1;

    localparam logic KIND_PULSE  = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_START,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

endpackage

>>> src/wheel_pulse_rpm_meter.sv
// Top level of the two-wheel period-measuring tachometer.
//
//  channel   direction  handshake            payload
//  s_        in         s_tvalid / s_tready  s_tdata, s_tuser
//  m_        out        m_tvalid / m_tready  m_tdata, m_tuser
//  cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A pulse request is taken while idle and leaves the sequencer idle. A sample request passes
// the accepting state, one check per wheel, a divider start, 34 steps and a capture per running
// wheel, and then the result load, which waits while a result waits on m_tready.
// A new request is taken while the previous result still waits in the output register.
// Reset (synchronous, active low) restores the register defaults and clears the stamps.
// Configuration writes are always taken.
`include "wheel_pulse_rpm_meter_defines.svh"

module wheel_pulse_rpm_meter (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [wprm_pkg::IN_DATA_W-1:0]     s_tdata,   // time_us
    input  logic [wprm_pkg::IN_USER_W-1:0]     s_tuser,   // kind, wheel
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [wprm_pkg::OUT_DATA_W-1:0]    m_tdata,   // right_speed_q8, left_speed_q8
    output logic [wprm_pkg::OUT_USER_W-1:0]    m_tuser,   // right_stopped, left_stopped
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [wprm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [wprm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    wprm_pkg::state_t state_reg, state_next;

    logic [wprm_pkg::WHEEL_IDX_W-1:0] wsel_reg, wsel_next;
    logic [wprm_pkg::TIME_WIDTH-1:0]  now_reg, now_next;
    logic [wprm_pkg::PPR_WIDTH-1:0]   ppr_reg, ppr_next;
    logic [wprm_pkg::TIME_WIDTH-1:0]  timeout_reg, timeout_next;
    logic [wprm_pkg::TIME_WIDTH-1:0]  last_reg [wprm_pkg::WHEEL_COUNT];
    logic [wprm_pkg::TIME_WIDTH-1:0]  prev_reg [wprm_pkg::WHEEL_COUNT];
    logic [wprm_pkg::DIV_WIDTH-1:0]   divisor_reg, divisor_next;
    logic [wprm_pkg::SPEED_WIDTH-1:0] speed_reg [wprm_pkg::WHEEL_COUNT];
    logic [wprm_pkg::WHEEL_COUNT-1:0] stop_reg;
    logic                             m_tvalid_reg, m_tvalid_next;
    logic [wprm_pkg::OUT_DATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [wprm_pkg::OUT_USER_W-1:0]  m_tuser_reg, m_tuser_next;

    logic                             in_kind;
    logic [wprm_pkg::WHEEL_IDX_W-1:0] in_wheel;
    logic [wprm_pkg::WHEEL_IDX_W-1:0] rd_idx;
    logic [wprm_pkg::TIME_WIDTH-1:0]  rd_last;
    logic [wprm_pkg::TIME_WIDTH-1:0]  rd_prev;
    logic [wprm_pkg::TIME_WIDTH-1:0]  elapsed;
    logic [wprm_pkg::TIME_WIDTH-1:0]  interval;
    logic                             wheel_stop;
    logic                             last_wheel;
    logic                             out_free;

    logic                             take_pulse;
    logic                             take_sample;
    logic                             check_now;
    logic                             div_start;
    logic                             div_capture;
    logic                             out_load;

    logic                             div_busy;
    logic                             div_done;
    logic [wprm_pkg::SPEED_WIDTH-1:0] div_quotient;

    assign in_kind  = s_tuser[0];
    assign in_wheel = wprm_pkg::WHEEL_IDX_W'(s_tuser[1]);

    // The stamp store is read at one place: the incoming wheel while idle, else the
    // wheel under check.
    assign rd_idx   = (state_reg == wprm_pkg::ST_IDLE) ? in_wheel : wsel_reg;
    assign rd_last  = last_reg[rd_idx];
    assign rd_prev  = prev_reg[rd_idx];
    assign elapsed  = now_reg - rd_last;
    assign interval = rd_last - rd_prev;

    // A wrap between the stamps and a zero interval both show as last <= previous.
    assign wheel_stop = (elapsed > timeout_reg) || (rd_last <= rd_prev) || (ppr_reg == '0);
    assign last_wheel = (wsel_reg == wprm_pkg::WHEEL_IDX_W'(wprm_pkg::WHEEL_COUNT - 1));
    assign out_free   = !m_tvalid_reg || m_tready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            wprm_pkg::ST_IDLE: begin
                if (s_tvalid && in_kind == wprm_pkg::KIND_SAMPLE) begin
                    state_next = wprm_pkg::ST_CHECK;
                end
            end
            wprm_pkg::ST_CHECK: begin
                if (!wheel_stop) begin
                    state_next = wprm_pkg::ST_START;
                end else if (last_wheel) begin
                    state_next = wprm_pkg::ST_FINISH;
                end
            end
            wprm_pkg::ST_START: begin
                state_next = wprm_pkg::ST_DIVIDE;
            end
            wprm_pkg::ST_DIVIDE: begin
                if (div_done) begin
                    state_next = last_wheel ? wprm_pkg::ST_FINISH : wprm_pkg::ST_CHECK;
                end
            end
            wprm_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = wprm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = wprm_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_tready    = 1'b0;
        take_pulse  = 1'b0;
        take_sample = 1'b0;
        check_now   = 1'b0;
        div_start   = 1'b0;
        div_capture = 1'b0;
        out_load    = 1'b0;
        unique case (state_reg)
            wprm_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                take_pulse  = s_tvalid && (in_kind == wprm_pkg::KIND_PULSE);
                take_sample = s_tvalid && (in_kind == wprm_pkg::KIND_SAMPLE);
            end
            wprm_pkg::ST_CHECK: begin
                check_now = 1'b1;
            end
            wprm_pkg::ST_START: begin
                div_start = 1'b1;
            end
            wprm_pkg::ST_DIVIDE: begin
                div_capture = div_done;
            end
            wprm_pkg::ST_FINISH: begin
                out_load = out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Configuration decode; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_comb begin
        ppr_next     = ppr_reg;
        timeout_next = timeout_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                wprm_pkg::REG_PPR:     ppr_next = cfg_data[wprm_pkg::PPR_WIDTH-1:0];
                wprm_pkg::REG_TIMEOUT: timeout_next = cfg_data[wprm_pkg::TIME_WIDTH-1:0];
                default:               ppr_next = ppr_reg;
            endcase
        end
    end

    always_comb begin
        wsel_next    = wsel_reg;
        now_next     = now_reg;
        divisor_next = divisor_reg;
        if (take_sample) begin
            wsel_next = '0;
            now_next  = s_tdata[wprm_pkg::TIME_WIDTH-1:0];
        end
        if (check_now) begin
            divisor_next = wprm_pkg::DIV_WIDTH'(interval) * wprm_pkg::DIV_WIDTH'(ppr_reg);
            if (wheel_stop && !last_wheel) begin
                wsel_next = wsel_reg + 1'b1;
            end
        end
        if (div_capture && !last_wheel) begin
            wsel_next = wsel_reg + 1'b1;
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (out_load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = '0;
            for (int w = 0; w < wprm_pkg::WHEEL_COUNT; w++) begin
                m_tdata_next[w*wprm_pkg::SPEED_WIDTH +: wprm_pkg::SPEED_WIDTH] = speed_reg[w];
            end
            m_tuser_next = stop_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= wprm_pkg::ST_IDLE;
            wsel_reg     <= '0;
            ppr_reg      <= wprm_pkg::PPR_RESET;
            timeout_reg  <= wprm_pkg::TIMEOUT_RESET;
            m_tvalid_reg <= 1'b0;
            for (int w = 0; w < wprm_pkg::WHEEL_COUNT; w++) begin
                last_reg[w] <= '0;
                prev_reg[w] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            wsel_reg     <= wsel_next;
            ppr_reg      <= ppr_next;
            timeout_reg  <= timeout_next;
            m_tvalid_reg <= m_tvalid_next;
            if (take_pulse) begin
                prev_reg[in_wheel] <= rd_last;
                last_reg[in_wheel] <= s_tdata[wprm_pkg::TIME_WIDTH-1:0];
            end
        end
        now_reg     <= now_next;
        divisor_reg <= divisor_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        if (check_now && wheel_stop) begin
            speed_reg[wsel_reg] <= '0;
            stop_reg[wsel_reg]  <= 1'b1;
        end
        if (div_capture) begin
            speed_reg[wsel_reg] <= div_quotient;
            stop_reg[wsel_reg]  <= 1'b0;
        end
    end

    wprm_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (wprm_pkg::NUMERATOR),
        .divisor  (divisor_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `WPRM_ASSERT_IMPLIES(a_no_overwrite, aclk, aresetn, out_load, !m_tvalid_reg || m_tready, "result register overwritten while a result waits")
    `WPRM_ASSERT_IMPLIES(a_start_idle_divider, aclk, aresetn, div_start, !div_busy, "divider restarted while busy")
    `WPRM_ASSERT_IMPLIES(a_right_stop_zero, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata[wprm_pkg::SPEED_WIDTH-1:0] == '0, "stopped wheel reports nonzero speed")
    `WPRM_ASSERT_NEXT(a_sample_busy, aclk, aresetn, s_tvalid && s_tready && s_tuser[0], !s_tready, "sample request did not occupy the sequencer")

endmodule

>>> src/wprm_divider.sv
// Restoring divider that produces one quotient bit per cycle.
module wprm_divider (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [wprm_pkg::SPEED_WIDTH-1:0]  dividend,
    input  logic [wprm_pkg::DIV_WIDTH-1:0]    divisor,
    output logic                              busy,
    output logic                              done,
    output logic [wprm_pkg::SPEED_WIDTH-1:0]  quotient
);

    logic [wprm_pkg::CNT_WIDTH-1:0]   count_reg, count_next;
    logic [wprm_pkg::SPEED_WIDTH-1:0] quo_reg, quo_next;
    logic [wprm_pkg::DIV_WIDTH-1:0]   rem_reg, rem_next;
    logic [wprm_pkg::DIV_WIDTH-1:0]   div_reg, div_next;
    logic                             done_reg, done_next;
    logic [wprm_pkg::DIV_WIDTH:0]     trial;
    logic [wprm_pkg::DIV_WIDTH:0]     diff;
    logic                             fits;

    // The remainder stays below the divisor, so the shifted trial is below twice it.
    assign trial = {rem_reg, quo_reg[wprm_pkg::SPEED_WIDTH-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign fits  = trial >= {1'b0, div_reg};

    always_comb begin
        count_next = count_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        done_next  = 1'b0;
        if (start) begin
            count_next = wprm_pkg::CNT_WIDTH'(wprm_pkg::SPEED_WIDTH);
            quo_next   = dividend;
            rem_next   = '0;
            div_next   = divisor;
        end else if (count_reg != '0) begin
            count_next = count_reg - 1'b1;
            quo_next   = {quo_reg[wprm_pkg::SPEED_WIDTH-2:0], fits};
            rem_next   = fits ? diff[wprm_pkg::DIV_WIDTH-1:0]
                              : trial[wprm_pkg::DIV_WIDTH-1:0];
            done_next  = (count_reg == wprm_pkg::CNT_WIDTH'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign busy     = (count_reg != '0);
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
